/* sv/gcdd_pkg.sv */
// Shared types and constants of the grid central-difference derivative block.
package gcdd_pkg;

	localparam int CFG_INDEX_W        = 3;
	localparam int CFG_DATA_W         = 32;
	localparam int ROW_W              = 16;
	localparam int COL_OUT_W          = 10;
	localparam int VALUE_W            = 32;
	localparam int GAIN_W             = 32;
	localparam int GAIN_FRAC          = 16;
	localparam int ROW_LENGTH_FIELD_W = 11;
	localparam int MIN_DIM            = 3;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AXIS_SELECT = 3'd0,
		REG_DERIV_ORDER = 3'd1,
		REG_ROW_LENGTH  = 3'd2,
		REG_ROW_COUNT   = 3'd3,
		REG_STEP_GAIN   = 3'd4
	} cfg_reg_t;

	// Settled configuration as seen by the datapath
	typedef struct packed {
		logic                     axis;
		logic                     order;
		logic signed [GAIN_W-1:0] gain;
		logic                     len3;
		logic                     cnt3;
		logic [ROW_W-1:0]         last_row;
	} cfg_t;

	// One result to send: either the freshly computed value or a held one
	typedef struct packed {
		logic                 valid;
		logic                 held;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
	} slot_t;

	// What one accepted sample produces, worked out at acceptance
	typedef struct packed {
		logic  axis;
		slot_t a;
		slot_t b;
		logic  hold_x;
		logic  hold_y;
	} plan_t;

endpackage

/* sv/gcdd_if.sv */
// Sample and result channel interfaces of the derivative block.
interface gcdd_sample_if #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface gcdd_result_if ();
	logic                                      valid;
	logic                                      ready;
	logic signed [gcdd_pkg::VALUE_W-1:0]       deriv_value;
	logic [gcdd_pkg::ROW_W-1:0]                out_row;
	logic [gcdd_pkg::COL_OUT_W-1:0]            out_column;
	logic                                      last_of_run;

	modport source (output valid, output deriv_value, output out_row, output out_column,
		output last_of_run, input ready);
	modport sink (input valid, input deriv_value, input out_row, input out_column,
		input last_of_run, output ready);
endinterface

/* sv/gcdd_cfg.sv */
// Configuration registers with clamping and frame restart request.
module gcdd_cfg #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int COL_W          = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gcdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gcdd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output gcdd_pkg::cfg_t                      cfg,
	output logic [COL_W-1:0]                    last_col,
	output logic                                restart
);
	localparam int ROW_W   = gcdd_pkg::ROW_W;
	localparam int GAIN_W  = gcdd_pkg::GAIN_W;
	localparam int FIELD_W = gcdd_pkg::ROW_LENGTH_FIELD_W;
	localparam int MIN_DIM = gcdd_pkg::MIN_DIM;

	logic                     axis_q;
	logic                     order_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic                     len3_q;
	logic                     cnt3_q;
	logic [ROW_W-1:0]         last_row_q;
	logic [COL_W-1:0]         last_col_q;
	logic [31:0]              len_c;
	logic [ROW_W-1:0]         cnt_c;

	// Clamp the written dimensions
	always_comb begin
		len_c = 32'(cfg_data[FIELD_W-1:0]);
		if (len_c < 32'(MIN_DIM)) len_c = 32'(MIN_DIM);
		if (len_c > 32'(MAX_ROW_LENGTH)) len_c = 32'(MAX_ROW_LENGTH);
		cnt_c = cfg_data[ROW_W-1:0];
		if (cnt_c < ROW_W'(MIN_DIM)) cnt_c = ROW_W'(MIN_DIM);
	end

	// Any write to a frame geometry or mode register restarts the frame
	always_comb begin
		case (cfg_index)
			gcdd_pkg::REG_AXIS_SELECT,
			gcdd_pkg::REG_DERIV_ORDER,
			gcdd_pkg::REG_ROW_LENGTH,
			gcdd_pkg::REG_ROW_COUNT: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q     <= 1'b0;
			order_q    <= 1'b0;
			gain_q     <= gcdd_pkg::GAIN_RESET;
			len3_q     <= 1'b1;
			cnt3_q     <= 1'b1;
			last_row_q <= ROW_W'(MIN_DIM - 1);
			last_col_q <= COL_W'(MIN_DIM - 1);
		end else if (cfg_we) begin
			case (cfg_index)
				gcdd_pkg::REG_AXIS_SELECT: axis_q <= cfg_data[0];
				gcdd_pkg::REG_DERIV_ORDER: order_q <= cfg_data[0];
				gcdd_pkg::REG_ROW_LENGTH: begin
					last_col_q <= COL_W'(len_c - 32'd1);
					len3_q     <= (len_c == 32'(MIN_DIM));
				end
				gcdd_pkg::REG_ROW_COUNT: begin
					last_row_q <= cnt_c - ROW_W'(1);
					cnt3_q     <= (cnt_c == ROW_W'(MIN_DIM));
				end
				gcdd_pkg::REG_STEP_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.axis     = axis_q;
		cfg.order    = order_q;
		cfg.gain     = gain_q;
		cfg.len3     = len3_q;
		cfg.cnt3     = cnt3_q;
		cfg.last_row = last_row_q;
	end

	assign last_col = last_col_q;

endmodule

/* sv/gcdd_seq.sv */
// Raster position tracking and per-sample result planning.
module gcdd_seq #(
	parameter int COL_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                restart,
	input  gcdd_pkg::cfg_t      cfg,
	input  logic [COL_W-1:0]    last_col,
	output logic [COL_W-1:0]    col,
	output gcdd_pkg::plan_t     plan
);
	localparam int ROW_W     = gcdd_pkg::ROW_W;
	localparam int COL_OUT_W = gcdd_pkg::COL_OUT_W;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 hx_pend_q;
	logic [ROW_W-1:0]     hx_row_q;
	logic                 frame_done_q;

	logic [COL_OUT_W-1:0] col10;
	logic [COL_OUT_W-1:0] col10_m1;
	logic                 col_last;
	logic                 row_last;
	logic                 comp;
	logic                 first;
	logic                 at_end;
	logic                 dim3;
	logic                 held;
	logic                 hold;
	gcdd_pkg::slot_t      e0;
	gcdd_pkg::slot_t      e1;
	gcdd_pkg::slot_t      e2;
	gcdd_pkg::slot_t      eh;

	function automatic gcdd_pkg::slot_t mk_slot(input logic is_held,
		input logic [ROW_W-1:0] r, input logic [COL_OUT_W-1:0] c);
		gcdd_pkg::slot_t s;
		s.valid = 1'b1;
		s.held  = is_held;
		s.row   = r;
		s.col   = c;
		return s;
	endfunction

	// Decide which results this position emits and in what order
	always_comb begin
		col10    = COL_OUT_W'(col_q);
		col10_m1 = COL_OUT_W'(col_q - COL_W'(1));
		col_last = (col_q == last_col);
		row_last = (row_q == cfg.last_row);
		if (cfg.axis) begin
			comp   = (row_q >= ROW_W'(2));
			first  = (row_q == ROW_W'(2));
			at_end = row_last;
			dim3   = cfg.cnt3;
			held   = (row_q == '0) && frame_done_q;
			e0     = mk_slot(1'b0, '0, col10);
			e1     = mk_slot(1'b0, row_q - ROW_W'(1), col10);
			e2     = mk_slot(1'b0, row_q, col10);
			eh     = mk_slot(1'b1, ROW_W'(2), col10);
		end else begin
			comp   = (col_q >= COL_W'(2));
			first  = (col_q == COL_W'(2));
			at_end = col_last;
			dim3   = cfg.len3;
			held   = hx_pend_q;
			e0     = mk_slot(1'b0, row_q, '0);
			e1     = mk_slot(1'b0, row_q, col10_m1);
			e2     = mk_slot(1'b0, row_q, col10);
			eh     = mk_slot(1'b1, hx_row_q, COL_OUT_W'(2));
		end
		hold = comp && at_end && dim3;

		plan.axis = cfg.axis;
		if (held) plan.a = eh;
		else if (comp) plan.a = first ? e0 : e1;
		else plan.a = '0;

		if (comp && first) plan.b = e1;
		else if (comp && at_end && !dim3) plan.b = e2;
		else plan.b = '0;

		plan.hold_x = hold && !cfg.axis;
		plan.hold_y = hold && cfg.axis;
	end

	// Advance the raster position and the held-result bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			hx_pend_q    <= 1'b0;
			hx_row_q     <= '0;
			frame_done_q <= 1'b0;
		end else if (restart) begin
			col_q        <= '0;
			row_q        <= '0;
			hx_pend_q    <= 1'b0;
			frame_done_q <= 1'b0;
		end else if (accept) begin
			hx_pend_q <= plan.hold_x;
			if (plan.hold_x) hx_row_q <= row_q;
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
					if (cfg.axis && cfg.cnt3) frame_done_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign col = col_q;

endmodule

/* sv/gcdd_line.sv */
// Neighbor fetch: row taps along x and a two-row line memory along y.
module gcdd_line #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int COL_W          = 10,
	parameter int SAMPLE_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          advance,
	input  logic                          valid_s1,
	input  logic                          axis,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [COL_W-1:0]              rd_col,
	input  logic [COL_W-1:0]              wr_col,
	output logic signed [SAMPLE_BITS-1:0] nxt,
	output logic signed [SAMPLE_BITS-1:0] ctr,
	output logic signed [SAMPLE_BITS-1:0] bfr
);
	localparam int SB = SAMPLE_BITS;

	// Entry layout: older row in the upper half, newer row in the lower half
	logic [2*SB-1:0]        line_mem [MAX_ROW_LENGTH];
	logic [2*SB-1:0]        rd_s1;
	logic signed [SB-1:0]   prev_one_q;
	logic signed [SB-1:0]   prev_two_q;
	logic signed [SB-1:0]   sample_s1;
	logic signed [SB-1:0]   x_ctr_s1;
	logic signed [SB-1:0]   x_bfr_s1;

	// Read the column at acceptance, write it back shifted by one row as the sample leaves the first stage
	always_ff @(posedge clk) begin
		if (accept) rd_s1 <= line_mem[rd_col];
		if (valid_s1 && advance) line_mem[wr_col] <= {rd_s1[SB-1:0], sample_s1};
	end

	// Capture the sample and the x neighbors
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			x_ctr_s1  <= prev_one_q;
			x_bfr_s1  <= prev_two_q;
		end
	end

	// Shift the row taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q <= '0;
			prev_two_q <= '0;
		end else if (accept) begin
			prev_two_q <= prev_one_q;
			prev_one_q <= sample;
		end
	end

	assign nxt = sample_s1;
	assign ctr = axis ? $signed(rd_s1[SB-1:0]) : x_ctr_s1;
	assign bfr = axis ? $signed(rd_s1[2*SB-1:SB]) : x_bfr_s1;

endmodule

/* sv/gcdd_scale.sv */
// Difference, gain multiply, Q16 shift and 32-bit saturation, three stages.
module gcdd_scale #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 advance,
	input  logic                                 order,
	input  logic signed [gcdd_pkg::GAIN_W-1:0]   gain,
	input  logic signed [SAMPLE_BITS-1:0]        nxt,
	input  logic signed [SAMPLE_BITS-1:0]        ctr,
	input  logic signed [SAMPLE_BITS-1:0]        bfr,
	output logic signed [gcdd_pkg::VALUE_W-1:0]  value
);
	localparam int VALUE_W = gcdd_pkg::VALUE_W;
	localparam int DIFF_W  = SAMPLE_BITS + 3;
	localparam int PROD_W  = DIFF_W + gcdd_pkg::GAIN_W;
	localparam int SHIFT_W = (PROD_W - gcdd_pkg::GAIN_FRAC > VALUE_W) ?
		(PROD_W - gcdd_pkg::GAIN_FRAC) : (VALUE_W + 1);
	localparam logic signed [SHIFT_W-1:0] SAT_HI =
		{{(SHIFT_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
	localparam logic signed [SHIFT_W-1:0] SAT_LO =
		{{(SHIFT_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

	logic signed [DIFF_W-1:0]  diff_d;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [SHIFT_W-1:0] shifted;
	logic signed [VALUE_W-1:0] sat;
	logic signed [VALUE_W-1:0] value_s4;

	// First or second central difference
	always_comb begin
		if (order) diff_d = DIFF_W'(nxt) + DIFF_W'(bfr) - (DIFF_W'(ctr) <<< 1);
		else diff_d = DIFF_W'(nxt) - DIFF_W'(bfr);
	end

	// Floor shift and clamp to the result range
	always_comb begin
		shifted = SHIFT_W'(prod_s3 >>> gcdd_pkg::GAIN_FRAC);
		if (shifted > SAT_HI) sat = VALUE_W'(SAT_HI);
		else if (shifted < SAT_LO) sat = VALUE_W'(SAT_LO);
		else sat = VALUE_W'(shifted);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s2  <= diff_d;
			prod_s3  <= PROD_W'(diff_s2) * PROD_W'(gain);
			value_s4 <= sat;
		end
	end

	assign value = value_s4;

endmodule

/* sv/gcdd_emit.sv */
// Result sequencing, held-result store and output register.
module gcdd_emit #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int COL_W          = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s4,
	input  gcdd_pkg::plan_t                     plan,
	input  logic signed [gcdd_pkg::VALUE_W-1:0] value,
	input  logic                                rd_en,
	input  logic [COL_W-1:0]                    rd_col,
	input  logic [COL_W-1:0]                    wr_col,
	output logic                                done,
	gcdd_result_if.source                       deriv
);
	localparam int VALUE_W   = gcdd_pkg::VALUE_W;
	localparam int ROW_W     = gcdd_pkg::ROW_W;
	localparam int COL_OUT_W = gcdd_pkg::COL_OUT_W;

	logic signed [VALUE_W-1:0] held_mem [MAX_ROW_LENGTH];
	logic signed [VALUE_W-1:0] hy_rd_q;
	logic signed [VALUE_W-1:0] hx_val_q;
	logic                      idx_q;
	logic                      ov_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [ROW_W-1:0]          row_q;
	logic [COL_OUT_W-1:0]      col_q;
	logic                      last_q;

	logic                      out_free;
	logic                      last;
	logic                      load;
	logic signed [VALUE_W-1:0] held_val;
	gcdd_pkg::slot_t           cur;

	// Pick the next result of the current sample
	always_comb begin
		out_free = !ov_q || deriv.ready;
		cur      = idx_q ? plan.b : plan.a;
		last     = idx_q || !plan.b.valid;
		load     = valid_s4 && plan.a.valid && out_free;
		done     = valid_s4 && (!plan.a.valid || (out_free && last));
		held_val = plan.axis ? hy_rd_q : hx_val_q;
	end

	// Held y results per column: read ahead of the stage, store on completion
	always_ff @(posedge clk) begin
		if (rd_en) hy_rd_q <= held_mem[rd_col];
		if (done && plan.hold_y) held_mem[wr_col] <= value;
	end

	// Output payload and held x result
	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= cur.held ? held_val : value;
			row_q  <= cur.row;
			col_q  <= cur.col;
			last_q <= last;
		end
		if (done && plan.hold_x) hx_val_q <= value;
	end

	// Output valid and result index within the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 1'b0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (deriv.ready) ov_q <= 1'b0;
			if (done) idx_q <= 1'b0;
			else if (load) idx_q <= 1'b1;
		end
	end

	assign deriv.valid       = ov_q;
	assign deriv.deriv_value = val_q;
	assign deriv.out_row     = row_q;
	assign deriv.out_column  = col_q;
	assign deriv.last_of_run = last_q;

endmodule

/* sv/grid_central_difference_derivative.sv */
// Streaming central-difference derivative of a raster grid: samples enter in raster order, one
// request per clock while the pipeline is not stalled, and first or second differences along x or y
// leave with row and column tags, scaled by a Q16.16 gain and saturated to 32 bits. A sample passes
// from acceptance to the output register through operand fetch at acceptance, then difference,
// multiply, shift and clamp, and result sequencing. The sustained input rate is one sample per clock
// while the output accepts; a sample that yields two results holds the sequencing stage until both
// have gone, so the single output register, one result per clock, sets the rate on those samples.
// Along y the two previous rows sit in one line memory that is read at acceptance and written back
// as the sample leaves the first stage; a second memory keeps per-column results held over a frame
// boundary when the frame has three rows. Neither memory is cleared after reset. Configuration
// writes only while the block is idle.
module grid_central_difference_derivative #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int SAMPLE_BITS    = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gcdd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gcdd_pkg::CFG_DATA_W-1:0]  cfg_data,
	gcdd_sample_if.sink                      grid,
	gcdd_result_if.source                    deriv
);
	localparam int COL_W = $clog2(MAX_ROW_LENGTH);

	gcdd_pkg::cfg_t                       cfg;
	logic [COL_W-1:0]                     last_col;
	logic                                 restart;
	logic                                 accept;
	logic                                 advance;
	logic                                 done;
	logic [COL_W-1:0]                     seq_col;
	gcdd_pkg::plan_t                      seq_plan;
	logic signed [SAMPLE_BITS-1:0]        nxt;
	logic signed [SAMPLE_BITS-1:0]        ctr;
	logic signed [SAMPLE_BITS-1:0]        bfr;
	logic signed [gcdd_pkg::VALUE_W-1:0]  value;

	logic                                 valid_s1;
	logic                                 valid_s2;
	logic                                 valid_s3;
	logic                                 valid_s4;
	gcdd_pkg::plan_t                      plan_s1;
	gcdd_pkg::plan_t                      plan_s2;
	gcdd_pkg::plan_t                      plan_s3;
	gcdd_pkg::plan_t                      plan_s4;
	logic [COL_W-1:0]                     col_s1;
	logic [COL_W-1:0]                     col_s2;
	logic [COL_W-1:0]                     col_s3;
	logic [COL_W-1:0]                     col_s4;

	// Whole pipeline moves when the sequencing stage frees up
	assign advance    = !valid_s4 || done;
	assign grid.ready = advance;
	assign accept     = grid.valid && advance;

	gcdd_cfg #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.COL_W(COL_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.last_col(last_col),
		.restart(restart)
	);

	gcdd_seq #(
		.COL_W(COL_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.restart(restart),
		.cfg(cfg),
		.last_col(last_col),
		.col(seq_col),
		.plan(seq_plan)
	);

	gcdd_line #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.COL_W(COL_W),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_line (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.advance(advance),
		.valid_s1(valid_s1),
		.axis(cfg.axis),
		.sample(grid.sample),
		.rd_col(seq_col),
		.wr_col(col_s1),
		.nxt(nxt),
		.ctr(ctr),
		.bfr(bfr)
	);

	gcdd_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk(clk),
		.advance(advance),
		.order(cfg.order),
		.gain(cfg.gain),
		.nxt(nxt),
		.ctr(ctr),
		.bfr(bfr),
		.value(value)
	);

	gcdd_emit #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.COL_W(COL_W)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s4(valid_s4),
		.plan(plan_s4),
		.value(value),
		.rd_en(advance && valid_s3),
		.rd_col(col_s3),
		.wr_col(col_s4),
		.done(done),
		.deriv(deriv)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Carry the plan and column alongside the datapath
	always_ff @(posedge clk) begin
		if (advance) begin
			plan_s1 <= seq_plan;
			plan_s2 <= plan_s1;
			plan_s3 <= plan_s2;
			plan_s4 <= plan_s3;
			col_s1  <= seq_col;
			col_s2  <= col_s1;
			col_s3  <= col_s2;
			col_s4  <= col_s3;
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the grid central-difference derivative block.
module tb_top;

	localparam int SAMPLE_BITS   = 24;
	localparam int MAX_COLS      = 1024;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int PHASES        = 13;
	localparam int HOLD_PHASE    = 3;
	localparam int PAUSE_PHASE   = 5;
	localparam int WIDE_PHASE    = 7;
	localparam int LONG_HOLD     = 300;

	localparam logic [gcdd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd5;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [gcdd_pkg::CFG_DATA_W-1:0] GAIN_MAX = 32'h7fff_ffff;
	localparam logic [gcdd_pkg::CFG_DATA_W-1:0] GAIN_MIN = 32'h8000_0000;
	localparam logic [gcdd_pkg::CFG_DATA_W-1:0] GAIN_NEG_ONE = 32'hffff_0000;
	localparam logic [gcdd_pkg::CFG_DATA_W-1:0] LENGTH_ALL_ONES = 32'h0000_07ff;
	localparam longint VALUE_TOP = 64'sd2147483647;
	localparam longint VALUE_BOTTOM = -64'sd2147483648;

	typedef struct packed {
		logic signed [gcdd_pkg::VALUE_W-1:0] value;
		logic [gcdd_pkg::ROW_W-1:0]          row;
		logic [gcdd_pkg::COL_OUT_W-1:0]      col;
		logic                                last;
	} deriv_result_t;

	// Tracks frame position, line history and held edge results; queues expected derivatives
	class derivative_scoreboard;
		logic                               axis;
		logic                               order;
		int                                 row_length;
		int                                 row_count;
		logic signed [gcdd_pkg::GAIN_W-1:0] gain;
		longint                             prev_one;
		longint                             prev_two;
		longint                             line_older[MAX_COLS];
		longint                             line_newer[MAX_COLS];
		int                                 col_pos;
		int                                 row_pos;
		bit                                 held_x_valid;
		longint                             held_x_value;
		int                                 held_x_row;
		bit                                 held_y_valid[MAX_COLS];
		longint                             held_y_value[MAX_COLS];
		deriv_result_t                      pending[$];
		int                                 errors;
		int                                 samples_seen;
		int                                 results_checked;

		function new();
			axis = 1'b0;
			order = 1'b0;
			row_length = gcdd_pkg::MIN_DIM;
			row_count = gcdd_pkg::MIN_DIM;
			gain = gcdd_pkg::GAIN_RESET;
			prev_one = 0;
			prev_two = 0;
			errors = 0;
			samples_seen = 0;
			results_checked = 0;
			restart_frame();
		endfunction

		// Return to row 0, column 0 and drop any held edge results
		function void restart_frame();
			col_pos = 0;
			row_pos = 0;
			held_x_valid = 1'b0;
			foreach (held_y_valid[i])
				held_y_valid[i] = 1'b0;
		endfunction

		function void write_register(logic [gcdd_pkg::CFG_INDEX_W-1:0] index,
			logic [gcdd_pkg::CFG_DATA_W-1:0] data);
			case (index)
				gcdd_pkg::REG_AXIS_SELECT: begin
					axis = data[0];
					restart_frame();
				end
				gcdd_pkg::REG_DERIV_ORDER: begin
					order = data[0];
					restart_frame();
				end
				gcdd_pkg::REG_ROW_LENGTH: begin
					row_length = int'(data[gcdd_pkg::ROW_LENGTH_FIELD_W-1:0]);
					if (row_length < gcdd_pkg::MIN_DIM)
						row_length = gcdd_pkg::MIN_DIM;
					if (row_length > MAX_COLS)
						row_length = MAX_COLS;
					restart_frame();
				end
				gcdd_pkg::REG_ROW_COUNT: begin
					row_count = int'(data[gcdd_pkg::ROW_W-1:0]);
					if (row_count < gcdd_pkg::MIN_DIM)
						row_count = gcdd_pkg::MIN_DIM;
					restart_frame();
				end
				gcdd_pkg::REG_STEP_GAIN: gain = data;
				default: ;
			endcase
		endfunction

		// Scaled, floored and saturated first or second central difference
		function longint central_diff(longint next_s, longint centre, longint prior);
			longint diff;
			longint scaled;
			diff = order ? next_s + prior - 2 * centre : next_s - prior;
			scaled = (diff * longint'(gain)) >>> gcdd_pkg::GAIN_FRAC;
			if (scaled > VALUE_TOP)
				scaled = VALUE_TOP;
			if (scaled < VALUE_BOTTOM)
				scaled = VALUE_BOTTOM;
			return scaled;
		endfunction

		function void push_result(longint v, int row, int col);
			deriv_result_t r;
			r.value = v[gcdd_pkg::VALUE_W-1:0];
			r.row = row[gcdd_pkg::ROW_W-1:0];
			r.col = col[gcdd_pkg::COL_OUT_W-1:0];
			r.last = 1'b0;
			pending.push_back(r);
		endfunction

		function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
			longint        sv;
			longint        v;
			int            before_count;
			deriv_result_t tail;
			sv = s;
			before_count = pending.size();
			if (!axis) begin
				// along the row: a held column 2 result goes out first
				if (held_x_valid) begin
					push_result(held_x_value, held_x_row, 2);
					held_x_valid = 1'b0;
				end
				if (col_pos >= 2) begin
					v = central_diff(sv, prev_one, prev_two);
					if (col_pos == 2)
						push_result(v, row_pos, 0);
					push_result(v, row_pos, col_pos - 1);
					if (col_pos == row_length - 1) begin
						if (row_length == gcdd_pkg::MIN_DIM) begin
							held_x_valid = 1'b1;
							held_x_value = v;
							held_x_row = row_pos;
						end else begin
							push_result(v, row_pos, col_pos);
						end
					end
				end
				prev_two = prev_one;
				prev_one = sv;
			end else begin
				// down the column: a held row 2 result goes out at row 0 of the next frame
				if (row_pos == 0 && held_y_valid[col_pos]) begin
					push_result(held_y_value[col_pos], 2, col_pos);
					held_y_valid[col_pos] = 1'b0;
				end
				if (row_pos >= 2) begin
					v = central_diff(sv, line_newer[col_pos], line_older[col_pos]);
					if (row_pos == 2)
						push_result(v, 0, col_pos);
					push_result(v, row_pos - 1, col_pos);
					if (row_pos == row_count - 1) begin
						if (row_count == gcdd_pkg::MIN_DIM) begin
							held_y_valid[col_pos] = 1'b1;
							held_y_value[col_pos] = v;
						end else begin
							push_result(v, row_pos, col_pos);
						end
					end
				end
				line_older[col_pos] = line_newer[col_pos];
				line_newer[col_pos] = sv;
			end
			// flag the final result of this request
			if (pending.size() > before_count) begin
				tail = pending.pop_back();
				tail.last = 1'b1;
				pending.push_back(tail);
			end
			// advance the raster position
			col_pos++;
			if (col_pos >= row_length) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= row_count)
					row_pos = 0;
			end
			samples_seen++;
		endfunction

		function void check_result(deriv_result_t got);
			deriv_result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: row %0d column %0d value %0d",
					got.row, got.col, got.value);
				errors++;
				return;
			end
			want = pending.pop_front();
			results_checked++;
			if (got.value !== want.value) begin
				$error("deriv_value: expected %0d, got %0d", want.value, got.value);
				errors++;
			end
			if (got.row !== want.row) begin
				$error("out_row: expected %0d, got %0d", want.row, got.row);
				errors++;
			end
			if (got.col !== want.col) begin
				$error("out_column: expected %0d, got %0d", want.col, got.col);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [gcdd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [gcdd_pkg::CFG_DATA_W-1:0]  cfg_data;

	derivative_scoreboard board;
	bit                   src_calm;
	bit                   sink_calm;
	int                   sink_hold;
	int                   settings_used;

	gcdd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
	gcdd_result_if result_bus ();

	grid_central_difference_derivative #(
		.MAX_ROW_LENGTH(MAX_COLS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.grid(sample_bus.sink),
		.deriv(result_bus.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one sample after a random gap and hold it until the block takes it
	task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.sample <= s;
		do @(posedge clk); while (sample_bus.ready !== 1'b1);
		board.note_sample(s);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline empty
	task automatic settle();
		int waited;
		sample_bus.valid <= 1'b0;
		waited = 0;
		while (board.pending.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [gcdd_pkg::CFG_INDEX_W-1:0] index,
		logic [gcdd_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		board.write_register(index, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] corner_sample(int i);
		case (i % 6)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return SAMPLE_MIN;
			4: return SAMPLE_MAX;
			default: return '1;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		logic [31:0] raw;
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: raw = $urandom_range(0, 63) - 32;
			default: raw = $urandom();
		endcase
		return raw[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [gcdd_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return gcdd_pkg::GAIN_RESET;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			3: return '0;
			4: return GAIN_NEG_ONE;
			5: return $urandom_range(0, 32'h3_ffff);
			6: return -$urandom_range(0, 32'h3_ffff);
			default: return $urandom();
		endcase
	endfunction

	// Mostly short rows; some writes fall below the minimum or carry junk above the field
	function automatic logic [gcdd_pkg::CFG_DATA_W-1:0] pick_length();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd2;
			2: return 32'd3;
			3: return 32'h0000_0803;
			4: return 32'd4;
			default: return $urandom_range(3, 12);
		endcase
	endfunction

	function automatic logic [gcdd_pkg::CFG_DATA_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd3;
			2: return 32'h0000_ffff;
			3: return 32'h0001_0004;
			default: return $urandom_range(3, 8);
		endcase
	endfunction

	// Result sink: check each accepted result, then stall a random number of cycles
	initial begin : result_sink
		deriv_result_t got;
		int            stall;
		result_bus.ready <= 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				got.value = result_bus.deriv_value;
				got.row = result_bus.out_row;
				got.col = result_bus.out_column;
				got.last = result_bus.last_of_run;
				board.check_result(got);
				stall = sink_calm ? 0 : $urandom_range(0, 8);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				result_bus.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int n_items;
		bit fixed_axis;
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_bus.valid <= 1'b0;
		sample_bus.sample <= '0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		sink_hold = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: three-column rows, so every row end holds its edge result
		for (int i = 0; i < 12; i++)
			send_sample(corner_sample(i));

		// three-row frames down the column, second order, saturating gain
		settle();
		write_reg(gcdd_pkg::REG_AXIS_SELECT, 32'd1);
		write_reg(gcdd_pkg::REG_DERIV_ORDER, 32'd1);
		write_reg(gcdd_pkg::REG_STEP_GAIN, GAIN_MAX);
		settings_used++;
		for (int i = 0; i < 12; i++)
			send_sample(corner_sample(i + 3));

		// random settings, one phase each
		for (int p = 0; p < PHASES; p++) begin
			settle();
			fixed_axis = (p == WIDE_PHASE || p == HOLD_PHASE);
			write_reg(gcdd_pkg::REG_AXIS_SELECT, fixed_axis ? 32'd0 : $urandom_range(0, 1));
			write_reg(gcdd_pkg::REG_DERIV_ORDER, $urandom_range(0, 1));
			write_reg(gcdd_pkg::REG_ROW_LENGTH,
				p == WIDE_PHASE ? LENGTH_ALL_ONES : pick_length());
			write_reg(gcdd_pkg::REG_ROW_COUNT, pick_count());
			write_reg(gcdd_pkg::REG_STEP_GAIN, pick_gain());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNMAPPED, $urandom());
			settings_used++;
			src_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			n_items = (p == WIDE_PHASE) ? 1030 : $urandom_range(50, 90);
			for (int i = 0; i < n_items; i++) begin
				if (i == n_items / 2) begin
					if (p == HOLD_PHASE) begin
						// back up the output while samples keep coming
						src_calm = 1'b1;
						sink_hold = LONG_HOLD;
					end else if (p == PAUSE_PHASE) begin
						settle();
					end else if (p % 3 == 2) begin
						// gain change mid-frame keeps the raster position
						settle();
						write_reg(gcdd_pkg::REG_STEP_GAIN, pick_gain());
						settings_used++;
					end
				end
				send_sample(pick_sample());
			end
		end

		settle();
		if (board.pending.size() != 0) begin
			$error("%0d expected results never arrived", board.pending.size());
			board.errors += board.pending.size();
		end
		$display("tb_top: %0d samples in, %0d results checked, %0d register settings used",
			board.samples_seen, board.results_checked, settings_used);
		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
